### hdl/gbp_pkg.sv
// Shared constants and control types for the gshare branch predictor.
package gbp_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int ADDR_W = 12;
    localparam int HIST_W = 12;
    localparam int CNT_W = 32;
    localparam int CTR_W = 2;

    localparam logic [HIST_W-1:0] HIST_MASK = 12'hFFF;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic commit;
    } t_gbp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_gbp_sts;

endpackage

### hdl/gbp_req_if.sv
// Request channel of the predictor: predict and update items.
interface gbp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [gbp_pkg::ADDR_W-1:0]  branch_address;
    logic                        predicted_taken;
    logic                        resolved_taken;

    modport source (
        output valid, operation, branch_address, predicted_taken, resolved_taken,
        input  ready
    );
    modport sink (
        input  valid, operation, branch_address, predicted_taken, resolved_taken,
        output ready
    );
endinterface

### hdl/gbp_rsp_if.sv
// Response channel of the predictor: one result item per request item.
interface gbp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       predict_taken;
    logic [gbp_pkg::CNT_W-1:0]  branch_count;
    logic [gbp_pkg::CNT_W-1:0]  mispredict_count;

    modport source (
        output valid, predict_taken, branch_count, mispredict_count,
        input  ready
    );
    modport sink (
        input  valid, predict_taken, branch_count, mispredict_count,
        output ready
    );
endinterface

### hdl/gbp_ctrl.sv
// Controller state machine: table clearing pass, item capture and commit.
module gbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gbp_pkg::t_gbp_sts i_sts,
    output gbp_pkg::t_gbp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   commit;

    // The result register is free when empty or being drained this cycle.
    assign commit = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.clear_wr = (r_state == ST_CLEAR);
    assign o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.commit = commit;

endmodule

### hdl/gbp_dpath.sv
// Datapath: counter table, global history, branch counts and result register.
module gbp_dpath #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbp_pkg::t_gbp_cmd           i_cmd,
    output gbp_pkg::t_gbp_sts           o_sts,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic                        i_operation,
    input  logic [gbp_pkg::ADDR_W-1:0]  i_branch_address,
    input  logic                        i_predicted_taken,
    input  logic                        i_resolved_taken,
    output logic                        o_predict_taken,
    output logic [gbp_pkg::CNT_W-1:0]   o_branch_count,
    output logic [gbp_pkg::CNT_W-1:0]   o_mispredict_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int HMAX = (1 << gbp_pkg::HIST_W) - 1;

    logic [gbp_pkg::CTR_W-1:0]  r_mem [TABLE_ENTRIES];
    logic [gbp_pkg::CTR_W-1:0]  r_rd_ctr;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_clr_addr;
    logic                       r_op;
    logic                       r_res;
    logic                       r_mis;
    logic                       r_mode;
    logic [gbp_pkg::HIST_W-1:0] r_hist;
    logic [gbp_pkg::CNT_W-1:0]  r_branches;
    logic [gbp_pkg::CNT_W-1:0]  r_mispred;
    logic                       r_out_taken;
    logic [gbp_pkg::CNT_W-1:0]  r_out_branches;
    logic [gbp_pkg::CNT_W-1:0]  r_out_mispred;

    logic [gbp_pkg::HIST_W-1:0] hashed;
    logic [IDX_W-1:0]           rd_idx;
    logic [gbp_pkg::CTR_W-1:0]  ctr_next;
    logic [gbp_pkg::CNT_W-1:0]  n_branches;
    logic [gbp_pkg::CNT_W-1:0]  n_mispred;
    logic                       taken;
    logic                       tbl_upd;
    logic                       mem_we;
    logic [IDX_W-1:0]           wr_idx;
    logic [gbp_pkg::CTR_W-1:0]  wr_data;

    // Index reduction: restoring compare-subtract against shifted copies of
    // the table size. The hashed value is below 2^12, so eight steps suffice
    // for the smallest table; steps whose shifted size reaches 2^12 drop out.
    always_comb begin
        logic [gbp_pkg::HIST_W-1:0] v;
        v = (i_branch_address ^ r_hist) & gbp_pkg::HIST_MASK;
        for (int k = 7; k >= 0; k--) begin
            if ((TABLE_ENTRIES << k) <= HMAX) begin
                if (int'(v) >= (TABLE_ENTRIES << k)) begin
                    v = v - gbp_pkg::HIST_W'(TABLE_ENTRIES << k);
                end
            end
        end
        hashed = v;
    end

    assign rd_idx = IDX_W'(hashed);

    always_comb begin
        if (r_res) begin
            ctr_next = (r_rd_ctr == gbp_pkg::CTR_MAX) ? r_rd_ctr : r_rd_ctr + 1'b1;
        end else begin
            ctr_next = (r_rd_ctr == gbp_pkg::CTR_MIN) ? r_rd_ctr : r_rd_ctr - 1'b1;
        end
    end

    assign taken = r_mode || (r_rd_ctr >= gbp_pkg::CTR_WEAK_TAKEN);
    assign n_branches = (r_branches == gbp_pkg::CNT_MAX) ? r_branches : r_branches + 1'b1;
    assign n_mispred = (r_mis && r_mispred != gbp_pkg::CNT_MAX) ? r_mispred + 1'b1
                                                                 : r_mispred;
    assign tbl_upd = i_cmd.commit && (r_op == gbp_pkg::OP_UPDATE) && !r_mode;

    assign mem_we = i_cmd.clear_wr || tbl_upd;
    assign wr_idx = i_cmd.clear_wr ? r_clr_addr : r_idx;
    assign wr_data = i_cmd.clear_wr ? gbp_pkg::CTR_WEAK_TAKEN : ctr_next;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_ctr <= r_mem[rd_idx];
        end
    end

    // Captured item fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= rd_idx;
            r_op <= i_operation;
            r_res <= i_resolved_taken;
            r_mis <= i_predicted_taken ^ i_resolved_taken;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_op == gbp_pkg::OP_UPDATE) begin
                r_out_taken <= 1'b0;
                r_out_branches <= n_branches;
                r_out_mispred <= n_mispred;
            end else begin
                r_out_taken <= taken;
                r_out_branches <= r_branches;
                r_out_mispred <= r_mispred;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_mode <= 1'b0;
            r_hist <= '0;
            r_branches <= '0;
            r_mispred <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.commit && (r_op == gbp_pkg::OP_UPDATE)) begin
                r_branches <= n_branches;
                r_mispred <= n_mispred;
            end
            if (tbl_upd) begin
                r_hist <= {r_hist[gbp_pkg::HIST_W-2:0], r_res};
            end
        end
    end

    assign o_sts.clear_last = (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1));
    assign o_predict_taken = r_out_taken;
    assign o_branch_count = r_out_branches;
    assign o_mispredict_count = r_out_mispred;

endmodule

### hdl/gshare_branch_predictor.sv
// Top level of the gshare branch predictor: controller, datapath, assertions.
// Each request item is captured in the idle state (registered table read)
// and committed from the execute state, which writes back the counter of an
// update item and registers the result item, once the result register is
// free. No new item is accepted before that commit. Reset: synchronous, active
// low; afterwards a clearing pass sets every counter to weakly taken, and no item is accepted meanwhile.
module gshare_branch_predictor #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    gbp_req_if.sink    i_req,
    gbp_rsp_if.source  o_rsp
);

    // Command and status between the controller and the datapath.
    gbp_pkg::t_gbp_cmd cmd;
    gbp_pkg::t_gbp_sts sts;

    // The controller sequences a clearing pass after reset, then for each
    // item a capture cycle (table read issued) and a commit cycle. The commit
    // waits while the result register still holds an item not yet taken, so
    // a new request is still accepted while the previous result waits.
    gbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the counter table, the global history, the two
    // saturating counts, the always-taken mode bit and the result register.
    gbp_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_operation        (i_req.operation),
        .i_branch_address   (i_req.branch_address),
        .i_predicted_taken  (i_req.predicted_taken),
        .i_resolved_taken   (i_req.resolved_taken),
        .o_predict_taken    (o_rsp.predict_taken),
        .o_branch_count     (o_rsp.branch_count),
        .o_mispredict_count (o_rsp.mispredict_count)
    );

    // A commit always leaves a result item in the output register.
    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_rsp.valid)
        else $error("commit did not produce a result item");

    // Only one item is in flight: an accepted item blocks the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item accepted while one is in flight");

    // No item is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_wr |-> !i_req.ready)
        else $error("item accepted during the clearing pass");

    // Capture and commit never coincide in the same cycle.
    a_capture_commit_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule
